// ===== rtl/smcu_pkg.sv =====
// Shared widths, microcode word layout and the control program of the mean/covariance unit.
package smcu_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_COUNT   = 4096;
	localparam int COUNT_BITS  = $clog2(MAX_COUNT + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int COV_BITS    = 32;
	localparam int MEAN_BITS   = 16;

	// Shared multiplier operands are signed and one bit wider than a sum.
	localparam int MUL_BITS    = SUM_BITS + 1;
	localparam int LO_BITS     = MUL_BITS - 1;
	localparam int ACC_BITS    = 64;

	// Magnitude of n*Sxy - Sx*Sy and width of the n*n divisor.
	localparam int MAG_BITS    = 2 * SUM_BITS - 2;
	localparam int DEN_BITS    = 2 * COUNT_BITS;
	localparam int ITER_BITS   = $clog2(MAG_BITS + 1);

	localparam int STEP_BITS   = 4;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t ST_IDLE = step_t'(0);
	localparam step_t ST_NN   = step_t'(1);
	localparam step_t ST_NLO  = step_t'(2);
	localparam step_t ST_NHI  = step_t'(3);
	localparam step_t ST_SXSY = step_t'(4);
	localparam step_t ST_SUB  = step_t'(5);
	localparam step_t ST_DCOV = step_t'(6);
	localparam step_t ST_WCOV = step_t'(7);
	localparam step_t ST_DMX  = step_t'(8);
	localparam step_t ST_WMX  = step_t'(9);
	localparam step_t ST_DMY  = step_t'(10);
	localparam step_t ST_WMY  = step_t'(11);
	localparam step_t ST_SMY  = step_t'(12);
	localparam step_t ST_EMIT = step_t'(13);

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_NN,
		MUL_NLO,
		MUL_NHI,
		MUL_SXSY
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_ADD,
		ACC_ADD_SH,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_COV,
		DIV_MX,
		DIV_MY
	} div_src_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_CLOSE,
		COND_DIV_BUSY,
		COND_OUT_FULL
	} cond_t;

	typedef struct packed {
		logic     take;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     den_load;
		div_src_t div_start;
		div_src_t div_store;
		logic     emit;
		cond_t    cond;
		step_t    next;
	} uword_t;

	localparam uword_t UW_NOP = '{
		take:      1'b0,
		mul_sel:   MUL_NONE,
		acc_op:    ACC_HOLD,
		den_load:  1'b0,
		div_start: DIV_NONE,
		div_store: DIV_NONE,
		emit:      1'b0,
		cond:      COND_NONE,
		next:      ST_IDLE
	};

	// Control store. The accumulator ends up holding n*Sxy - Sx*Sy, with n*Sxy
	// built from a low and a high partial product of Sxy.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = UW_NOP;
		case (step)
			ST_IDLE: begin
				w.take = 1'b1;
				w.cond = COND_CLOSE;
				w.next = ST_NN;
			end
			ST_NN: begin
				w.mul_sel = MUL_NN;
				w.acc_op  = ACC_CLR;
				w.next    = ST_NLO;
			end
			ST_NLO: begin
				w.mul_sel  = MUL_NLO;
				w.den_load = 1'b1;
				w.next     = ST_NHI;
			end
			ST_NHI: begin
				w.mul_sel = MUL_NHI;
				w.acc_op  = ACC_ADD;
				w.next    = ST_SXSY;
			end
			ST_SXSY: begin
				w.mul_sel = MUL_SXSY;
				w.acc_op  = ACC_ADD_SH;
				w.next    = ST_SUB;
			end
			ST_SUB: begin
				w.acc_op = ACC_SUB;
				w.next   = ST_DCOV;
			end
			ST_DCOV: begin
				w.div_start = DIV_COV;
				w.next      = ST_WCOV;
			end
			ST_WCOV: begin
				w.cond = COND_DIV_BUSY;
				w.next = ST_DMX;
			end
			ST_DMX: begin
				w.div_store = DIV_COV;
				w.div_start = DIV_MX;
				w.next      = ST_WMX;
			end
			ST_WMX: begin
				w.cond = COND_DIV_BUSY;
				w.next = ST_DMY;
			end
			ST_DMY: begin
				w.div_store = DIV_MX;
				w.div_start = DIV_MY;
				w.next      = ST_WMY;
			end
			ST_WMY: begin
				w.cond = COND_DIV_BUSY;
				w.next = ST_SMY;
			end
			ST_SMY: begin
				w.div_store = DIV_MY;
				w.next      = ST_EMIT;
			end
			ST_EMIT: begin
				w.emit = 1'b1;
				w.cond = COND_OUT_FULL;
				w.next = ST_IDLE;
			end
			default: begin
				w.next = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/streaming_mean_covariance_unit.sv =====
// Top level of the streaming mean and covariance unit with its microcoded sequencer.
//
// Usage: samples arrive on the input channel (in_valid/in_ready) one pair per item.
// An item with has_sample set adds its pair to the running count and sums; an item
// with last_sample set closes the run and produces one result on the output
// channel (out_valid/out_ready). While a run is being accumulated the block takes
// one item every cycle. The closing item starts a short control program that forms
// n*Sxy - Sx*Sy with a shared 30x30 multiplier and then runs three divisions on a
// bit-serial divider (covariance, mean of x, mean of y). in_ready stays low from
// the acceptance of the closing item until the result has been written. The result
// then waits in an output register, so the next run can be accumulated while the
// receiver stalls; only the writing of that next run's result waits until the
// output register has been emptied. Pairs beyond 4096 per run are dropped and
// flagged. The variance_mode register is written over the cfg channel, which is
// always ready. Reset clears the run, the mode and all valid flags; in_ready is
// already high when reset is released, so the first item can be taken right away.
module streaming_mean_covariance_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [smcu_pkg::SAMPLE_BITS-1:0] x_sample,
	input  logic signed [smcu_pkg::SAMPLE_BITS-1:0] y_sample,
	input  logic                                has_sample,
	input  logic                                last_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [smcu_pkg::COV_BITS-1:0]  covariance,
	output logic signed [smcu_pkg::MEAN_BITS-1:0] mean_x,
	output logic signed [smcu_pkg::MEAN_BITS-1:0] mean_y,
	output logic [smcu_pkg::COUNT_BITS-1:0]       sample_count,
	output logic                                overflow
);

	// Sequencer state and the current control word.
	smcu_pkg::step_t  step_q;
	smcu_pkg::step_t  step_d;
	smcu_pkg::uword_t uw;

	logic variance_mode_q;

	// Run accumulators.
	logic [smcu_pkg::COUNT_BITS-1:0]        count_q;
	logic signed [smcu_pkg::SUM_BITS-1:0]   sum_x_q;
	logic signed [smcu_pkg::SUM_BITS-1:0]   sum_y_q;
	logic signed [smcu_pkg::PROD_BITS-1:0]  sum_prod_q;
	logic                                   dropped_q;

	// The per-pair product is registered before it is added to the running sum.
	logic signed [2*smcu_pkg::SAMPLE_BITS-1:0] prod_s1;
	logic                                      prod_vld_s1;

	// Close-of-run datapath.
	logic signed [smcu_pkg::MUL_BITS-1:0]   mul_a;
	logic signed [smcu_pkg::MUL_BITS-1:0]   mul_b;
	logic signed [smcu_pkg::MUL_BITS-1:0]   mul_n;
	logic signed [2*smcu_pkg::MUL_BITS-1:0] mul_p_q;
	logic signed [smcu_pkg::ACC_BITS-1:0]   mul_p_ext;
	logic signed [smcu_pkg::ACC_BITS-1:0]   acc_q;
	logic [smcu_pkg::DEN_BITS-1:0]          den_q;

	logic signed [smcu_pkg::ACC_BITS-1:0] div_src;
	logic [smcu_pkg::ACC_BITS-1:0]        div_abs;
	logic [smcu_pkg::DEN_BITS-1:0]        div_den;
	logic                                 div_start;
	logic                                 div_busy;
	logic                                 div_neg_q;
	logic [smcu_pkg::MAG_BITS-1:0]        div_quo;
	logic [smcu_pkg::MAG_BITS-1:0]        div_val;

	logic [smcu_pkg::COV_BITS-1:0]  cov_q;
	logic [smcu_pkg::MEAN_BITS-1:0] mx_q;
	logic [smcu_pkg::MEAN_BITS-1:0] my_q;

	logic out_valid_q;
	logic in_fire;
	logic close_fire;
	logic out_free;
	logic emit;
	logic room;
	logic signed [smcu_pkg::SAMPLE_BITS-1:0] y_eff;

	assign uw = smcu_pkg::ucode(step_q);

	assign cfg_ready  = 1'b1;
	assign in_ready   = uw.take;
	assign in_fire    = in_valid & in_ready;
	assign close_fire = in_fire & last_sample;
	assign out_free   = !out_valid_q || out_ready;
	assign emit       = uw.emit && out_free;
	assign out_valid  = out_valid_q;

	// In variance mode the x sample stands in for y, so mean_y equals mean_x.
	assign y_eff = variance_mode_q ? x_sample : y_sample;
	assign room  = (count_q < smcu_pkg::COUNT_BITS'(smcu_pkg::MAX_COUNT));

	// Step sequencing: the condition field either advances or holds the step.
	always_comb begin
		case (uw.cond)
			smcu_pkg::COND_NONE:     step_d = uw.next;
			smcu_pkg::COND_CLOSE:    step_d = close_fire ? uw.next : step_q;
			smcu_pkg::COND_DIV_BUSY: step_d = div_busy ? step_q : uw.next;
			smcu_pkg::COND_OUT_FULL: step_d = out_free ? uw.next : step_q;
			default:                 step_d = smcu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= smcu_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variance_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			variance_mode_q <= cfg_data;
		end
	end

	// Accumulation. A full run keeps its sums and only raises the dropped flag.
	// The product of the closing pair lands in the sum during the first program step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_prod_q  <= '0;
			dropped_q   <= 1'b0;
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= 1'b0;
			if (emit) begin
				count_q    <= '0;
				sum_x_q    <= '0;
				sum_y_q    <= '0;
				sum_prod_q <= '0;
				dropped_q  <= 1'b0;
			end else begin
				if (in_fire && has_sample) begin
					if (room) begin
						count_q     <= count_q + 1'b1;
						sum_x_q     <= sum_x_q + smcu_pkg::SUM_BITS'(x_sample);
						sum_y_q     <= sum_y_q + smcu_pkg::SUM_BITS'(y_eff);
						prod_vld_s1 <= 1'b1;
					end else begin
						dropped_q <= 1'b1;
					end
				end
				if (prod_vld_s1) begin
					sum_prod_q <= sum_prod_q + smcu_pkg::PROD_BITS'(prod_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_s1 <= (2*smcu_pkg::SAMPLE_BITS)'(x_sample)
				* (2*smcu_pkg::SAMPLE_BITS)'(y_eff);
		end
	end

	// Shared multiplier operand selection. Sxy is split into an unsigned low part
	// and a signed high part so that n*Sxy fits two passes of the multiplier.
	assign mul_n = signed'({{(smcu_pkg::MUL_BITS-smcu_pkg::COUNT_BITS){1'b0}}, count_q});

	always_comb begin
		case (uw.mul_sel)
			smcu_pkg::MUL_NN: begin
				mul_a = mul_n;
				mul_b = mul_n;
			end
			smcu_pkg::MUL_NLO: begin
				mul_a = mul_n;
				mul_b = signed'({1'b0, sum_prod_q[smcu_pkg::LO_BITS-1:0]});
			end
			smcu_pkg::MUL_NHI: begin
				mul_a = mul_n;
				mul_b = smcu_pkg::MUL_BITS'(
					signed'(sum_prod_q[smcu_pkg::PROD_BITS-1:smcu_pkg::LO_BITS]));
			end
			smcu_pkg::MUL_SXSY: begin
				mul_a = smcu_pkg::MUL_BITS'(sum_x_q);
				mul_b = smcu_pkg::MUL_BITS'(sum_y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.mul_sel != smcu_pkg::MUL_NONE) begin
			mul_p_q <= mul_a * mul_b;
		end
		if (uw.den_load) begin
			den_q <= mul_p_q[smcu_pkg::DEN_BITS-1:0];
		end
	end

	assign mul_p_ext = smcu_pkg::ACC_BITS'(mul_p_q);

	always_ff @(posedge clk) begin
		case (uw.acc_op)
			smcu_pkg::ACC_CLR:    acc_q <= '0;
			smcu_pkg::ACC_ADD:    acc_q <= acc_q + mul_p_ext;
			smcu_pkg::ACC_ADD_SH: acc_q <= acc_q + (mul_p_ext <<< smcu_pkg::LO_BITS);
			smcu_pkg::ACC_SUB:    acc_q <= acc_q - mul_p_ext;
			default:              acc_q <= acc_q;
		endcase
	end

	// Signed division truncated toward zero: divide magnitudes, restore the sign.
	always_comb begin
		case (uw.div_start)
			smcu_pkg::DIV_COV: begin
				div_src = acc_q;
				div_den = den_q;
			end
			smcu_pkg::DIV_MX: begin
				div_src = smcu_pkg::ACC_BITS'(sum_x_q);
				div_den = smcu_pkg::DEN_BITS'(count_q);
			end
			smcu_pkg::DIV_MY: begin
				div_src = smcu_pkg::ACC_BITS'(sum_y_q);
				div_den = smcu_pkg::DEN_BITS'(count_q);
			end
			default: begin
				div_src = acc_q;
				div_den = den_q;
			end
		endcase
	end

	assign div_abs   = div_src[smcu_pkg::ACC_BITS-1] ? unsigned'(-div_src) : unsigned'(div_src);
	assign div_start = (uw.div_start != smcu_pkg::DIV_NONE);
	assign div_val   = div_neg_q ? (~div_quo + 1'b1) : div_quo;

	smcu_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_abs[smcu_pkg::MAG_BITS-1:0]),
		.den      (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_neg_q <= div_src[smcu_pkg::ACC_BITS-1];
		end
		case (uw.div_store)
			smcu_pkg::DIV_COV: cov_q <= div_val[smcu_pkg::COV_BITS-1:0];
			smcu_pkg::DIV_MX:  mx_q  <= div_val[smcu_pkg::MEAN_BITS-1:0];
			smcu_pkg::DIV_MY:  my_q  <= div_val[smcu_pkg::MEAN_BITS-1:0];
			default: begin
			end
		endcase
	end

	// Output register. An empty run reports zeros, whatever the divider left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (count_q == '0) begin
				covariance <= '0;
				mean_x     <= '0;
				mean_y     <= '0;
			end else begin
				covariance <= signed'(cov_q);
				mean_x     <= signed'(mx_q);
				mean_y     <= signed'(my_q);
			end
			sample_count <= count_q;
			overflow     <= dropped_q;
		end
	end

	// The divider only runs while the program waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (uw.cond == smcu_pkg::COND_DIV_BUSY))
		else $error("divider busy outside a wait step");

	// The pair count never passes the run limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smcu_pkg::COUNT_BITS'(smcu_pkg::MAX_COUNT))
		else $error("pair count beyond limit");

	// A pending product is folded in before the program reads Sxy.
	assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_s1 |-> (step_q == smcu_pkg::ST_IDLE || step_q == smcu_pkg::ST_NN))
		else $error("product still pending when Sxy is used");

	// A result written to the output register is offered next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result lost at output register");

endmodule

// ===== rtl/smcu_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module smcu_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smcu_pkg::MAG_BITS-1:0] num,
	input  logic [smcu_pkg::DEN_BITS-1:0] den,
	output logic                          busy,
	output logic [smcu_pkg::MAG_BITS-1:0] quotient
);

	logic [smcu_pkg::MAG_BITS-1:0]  quo_q;
	logic [smcu_pkg::DEN_BITS-1:0]  rem_q;
	logic [smcu_pkg::DEN_BITS-1:0]  den_q;
	logic [smcu_pkg::ITER_BITS-1:0] cnt_q;
	logic [smcu_pkg::DEN_BITS:0]    trial;
	logic                           fits;

	// The numerator shifts out of the top of quo_q while quotient bits enter below.
	assign trial    = {rem_q, quo_q[smcu_pkg::MAG_BITS-1]};
	assign fits     = (trial >= {1'b0, den_q});
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= smcu_pkg::ITER_BITS'(smcu_pkg::MAG_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (fits) begin
				rem_q <= smcu_pkg::DEN_BITS'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[smcu_pkg::DEN_BITS-1:0];
			end
			quo_q <= {quo_q[smcu_pkg::MAG_BITS-2:0], fits};
		end
	end

endmodule
